>>> design/sff_pkg.sv
// sff_pkg: widths, payload types and status codes for the four-point sphere fit
// used by sff_front, sff_queue, sff_back and sphere_from_four_points
package sff_pkg;

    localparam int COORD_BITS = 16;
    localparam int IN_W       = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int Q_W        = 2 * DIFF_W;
    localparam int COF_W      = 2 * DIFF_W + 1;
    localparam int DEN_W      = DIFF_W + COF_W + 2;
    localparam int NUM_W      = Q_W + COF_W + 3;
    localparam int MAG_W      = NUM_W + 1;
    localparam int DIV_W      = DEN_W;
    localparam int REM_W      = DIV_W + 1;
    localparam int OFF_W      = MAG_W + 1;
    localparam int CEN_W      = 32;
    localparam int RAD_W      = 32;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int SQRT_STEPS = RAD_W;
    localparam int SREM_W     = RAD_W + 4;
    localparam int Q_DEPTH    = 16;
    localparam int Q_AW       = 4;

    localparam logic [SQ_W-1:0]  RAD_LIMIT = {{RAD_W{1'b1}}, {RAD_W{1'b0}}};
    localparam logic [CEN_W-1:0] CEN_MAX   = {1'b0, {(CEN_W-1){1'b1}}};
    localparam logic [CEN_W-1:0] CEN_MIN   = {1'b1, {(CEN_W-1){1'b0}}};

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COPLANAR  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] p0_x;
        logic signed [IN_W-1:0] p0_y;
        logic signed [IN_W-1:0] p0_z;
        logic signed [IN_W-1:0] p1_x;
        logic signed [IN_W-1:0] p1_y;
        logic signed [IN_W-1:0] p1_z;
        logic signed [IN_W-1:0] p2_x;
        logic signed [IN_W-1:0] p2_y;
        logic signed [IN_W-1:0] p2_z;
        logic signed [IN_W-1:0] p3_x;
        logic signed [IN_W-1:0] p3_y;
        logic signed [IN_W-1:0] p3_z;
    } sff_in_t;

    typedef struct packed {
        logic signed [CEN_W-1:0] centre_x;
        logic signed [CEN_W-1:0] centre_y;
        logic signed [CEN_W-1:0] centre_z;
        logic [RAD_W-1:0]        sphere_radius;
        logic [1:0]              fit_status;
    } sff_out_t;

    typedef struct packed {
        logic [2:0]                  neg;
        logic [2:0][COORD_BITS-1:0]  org;
        logic                        coplanar;
    } sff_side_t;

    // one request between front and back: per-axis dividend magnitude, shared divisor
    typedef struct packed {
        sff_side_t             side;
        logic [2:0][MAG_W-1:0] mag;
        logic [DIV_W-1:0]      dvs;
    } sff_mid_t;

    function automatic logic signed [COORD_BITS-1:0] coord_low(input logic [IN_W-1:0] f);
        logic [IN_W+COORD_BITS-1:0] z;
        z = {{COORD_BITS{1'b0}}, f};
        return z[COORD_BITS-1:0];
    endfunction

endpackage

>>> design/sff_front.sv
// sff_front: five-stage pipeline from four points to the centre division operands
// depends on sff_pkg
module sff_front import sff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  sff_in_t  pts,
    output logic     out_valid,
    output sff_mid_t item
);

    logic [4:0] vf_reg;

    logic signed [COORD_BITS-1:0] pt [0:3][0:2];

    logic signed [DIFF_W-1:0]     d1_reg [0:2][0:2];
    logic signed [COORD_BITS-1:0] org1_reg [0:2];

    logic signed [COF_W-1:0]      cof_next [0:2][0:2];
    logic [Q_W-1:0]               q_next [0:2];
    logic signed [COF_W-1:0]      cof2_reg [0:2][0:2];
    logic [Q_W-1:0]               q2_reg [0:2];
    logic signed [DIFF_W-1:0]     col2_reg [0:2];
    logic signed [COORD_BITS-1:0] org2_reg [0:2];

    logic signed [DEN_W-1:0]      pden3_reg [0:2];
    logic signed [NUM_W-1:0]      pnum3_reg [0:2][0:2];
    logic signed [COORD_BITS-1:0] org3_reg [0:2];

    logic signed [DEN_W-1:0]      den4_reg;
    logic signed [NUM_W-1:0]      num4_reg [0:2];
    logic signed [COORD_BITS-1:0] org4_reg [0:2];

    sff_mid_t item_next;
    sff_mid_t item_reg;

    always_comb
    begin
        pt[0][0] = coord_low(pts.p0_x);
        pt[0][1] = coord_low(pts.p0_y);
        pt[0][2] = coord_low(pts.p0_z);
        pt[1][0] = coord_low(pts.p1_x);
        pt[1][1] = coord_low(pts.p1_y);
        pt[1][2] = coord_low(pts.p1_z);
        pt[2][0] = coord_low(pts.p2_x);
        pt[2][1] = coord_low(pts.p2_y);
        pt[2][2] = coord_low(pts.p2_z);
        pt[3][0] = coord_low(pts.p3_x);
        pt[3][1] = coord_low(pts.p3_y);
        pt[3][2] = coord_low(pts.p3_z);
    end

    // signed cofactors by cyclic indexing, squared row lengths
    always_comb
    begin
        logic signed [Q_W:0] sqs;
        int i1, i2, k1, k2;
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int k = 0; k < 3; k++)
            begin
                k1 = (k + 1) % 3;
                k2 = (k + 2) % 3;
                cof_next[i][k] = COF_W'(d1_reg[i1][k1]) * COF_W'(d1_reg[i2][k2])
                               - COF_W'(d1_reg[i1][k2]) * COF_W'(d1_reg[i2][k1]);
            end
            sqs = (Q_W+1)'(d1_reg[i][0]) * (Q_W+1)'(d1_reg[i][0])
                + (Q_W+1)'(d1_reg[i][1]) * (Q_W+1)'(d1_reg[i][1])
                + (Q_W+1)'(d1_reg[i][2]) * (Q_W+1)'(d1_reg[i][2]);
            q_next[i] = sqs[Q_W-1:0];
        end
    end

    // sign fold so the divisor is not negative; negative dividends become floor magnitudes
    always_comb
    begin
        logic                     neg;
        logic signed [DEN_W-1:0]  ad;
        logic signed [NUM_W-1:0]  nk;
        logic signed [MAG_W-1:0]  np;
        neg = den4_reg[DEN_W-1];
        ad  = neg ? -den4_reg : den4_reg;
        item_next.dvs = DIV_W'(ad) << 1;
        item_next.side.coplanar = (den4_reg == '0);
        for (int k = 0; k < 3; k++)
        begin
            nk = neg ? -num4_reg[k] : num4_reg[k];
            np = MAG_W'(nk) + MAG_W'(ad);
            item_next.side.neg[k] = np[MAG_W-1];
            item_next.side.org[k] = org4_reg[k];
            item_next.mag[k] = np[MAG_W-1] ? (~np + MAG_W'(item_next.dvs)) : np;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            org1_reg[k] <= pt[0][k];
            org2_reg[k] <= org1_reg[k];
            org3_reg[k] <= org2_reg[k];
            org4_reg[k] <= org3_reg[k];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[i][k]    <= DIFF_W'(pt[i+1][k]) - DIFF_W'(pt[0][k]);
                cof2_reg[i][k]  <= cof_next[i][k];
                pnum3_reg[k][i] <= NUM_W'($signed({1'b0, q2_reg[i]}))
                                 * NUM_W'(cof2_reg[i][k]);
            end
            q2_reg[i]    <= q_next[i];
            col2_reg[i]  <= d1_reg[i][0];
            pden3_reg[i] <= DEN_W'(col2_reg[i]) * DEN_W'(cof2_reg[i][0]);
        end
        den4_reg <= pden3_reg[0] + pden3_reg[1] + pden3_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            num4_reg[k] <= pnum3_reg[k][0] + pnum3_reg[k][1] + pnum3_reg[k][2];
        end
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
        end
        else
        begin
            vf_reg <= {vf_reg[3:0], take};
        end
    end

    assign out_valid = vf_reg[4];
    assign item      = item_reg;

endmodule

>>> design/sff_queue.sv
// sff_queue: credit-counted queue between front and back, memory plus head register
// depends on sff_pkg
module sff_queue import sff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     reserve,
    output logic     full,
    input  logic     wr,
    input  sff_mid_t wdata,
    output logic     head_valid,
    output sff_mid_t head,
    input  logic     rd
);

    sff_mid_t mem [0:Q_DEPTH-1];

    logic [Q_AW-1:0] wptr_reg, rptr_reg;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic [Q_AW:0]   cred_reg, cred_next;
    logic            head_valid_reg, head_valid_next;
    sff_mid_t        head_reg;
    logic            load;

    // credits cover requests still in the front pipeline, so the memory never overflows
    assign full = (cred_reg == (Q_AW+1)'(Q_DEPTH));
    assign load = (cnt_reg != '0) && (!head_valid_reg || rd);

    always_comb
    begin
        cred_next = cred_reg + (Q_AW+1)'(reserve) - (Q_AW+1)'(rd);
        cnt_next  = cnt_reg + (Q_AW+1)'(wr) - (Q_AW+1)'(load);
        head_valid_next = load ? 1'b1 : (rd ? 1'b0 : head_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (load)
        begin
            head_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            cnt_reg        <= '0;
            cred_reg       <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg       <= wptr_reg + Q_AW'(wr);
            rptr_reg       <= rptr_reg + Q_AW'(load);
            cnt_reg        <= cnt_next;
            cred_reg       <= cred_next;
            head_valid_reg <= head_valid_next;
        end
    end

    assign head_valid = head_valid_reg;
    assign head       = head_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (cnt_reg != (Q_AW+1)'(Q_DEPTH)) || load)
        else $error("queue memory written while full");

    a_cred_cover: assert property (@(posedge clk) disable iff (!rst_n)
        cred_reg >= cnt_reg + (Q_AW+1)'(head_valid_reg))
        else $error("queue holds more requests than credits");

    a_rd_head: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> head_valid_reg)
        else $error("queue read with no head");

endmodule

>>> design/sff_back.sv
// sff_back: pipelined restoring division, centre saturation, radius square root,
// and the result register; depends on sff_pkg
module sff_back import sff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  sff_mid_t in_item,
    output logic     in_take,
    output logic     res_valid,
    output sff_out_t res,
    input  logic     res_pop
);

    typedef struct packed {
        logic [2:0][CEN_W-1:0] cen;
        logic                  satc;
        logic                  rsat;
        logic                  cop;
    } info_t;

    logic en;

    logic [MAG_W:0]             dv_reg;
    logic [REM_W+MAG_W-1:0]     da_reg [0:MAG_W][0:2];
    logic [DIV_W-1:0]           dd_reg [0:MAG_W-1];
    sff_side_t                  ds_reg [0:MAG_W];

    logic                       x1_v_reg;
    logic [CEN_W-1:0]           x1_cen_next [0:2];
    logic [SQ_W-1:0]            x1_sq_next [0:2];
    logic                       x1_satc_next, x1_big_next;
    logic [CEN_W-1:0]           x1_cen_reg [0:2];
    logic [SQ_W-1:0]            x1_sq_reg [0:2];
    logic                       x1_satc_reg, x1_big_reg, x1_cop_reg;

    logic [SQ_W+1:0]            r2;
    info_t                      info0;

    logic [SQRT_STEPS:0]        sv_reg;
    logic [SREM_W-1:0]          sr_rem_reg [0:SQRT_STEPS];
    logic [RAD_W-1:0]           sr_root_reg [0:SQRT_STEPS];
    logic [SQ_W-1:0]            sr_v_reg [0:SQRT_STEPS-1];
    info_t                      sr_info_reg [0:SQRT_STEPS];
    logic [SREM_W-1:0]          sr_rem_next [1:SQRT_STEPS];
    logic [RAD_W-1:0]           sr_root_next [1:SQRT_STEPS];

    logic                       res_valid_reg;
    sff_out_t                   res_reg, res_next;

    function automatic logic [REM_W+MAG_W-1:0] div_step(
        input logic [REM_W+MAG_W-1:0] a,
        input logic [DIV_W-1:0]       d
    );
        logic [REM_W+MAG_W-1:0] s;
        logic [REM_W:0]         diff;
        s    = a << 1;
        diff = {1'b0, s[REM_W+MAG_W-1:MAG_W]} - (REM_W+1)'(d);
        if (!diff[REM_W])
        begin
            s[REM_W+MAG_W-1:MAG_W] = diff[REM_W-1:0];
            s[0] = 1'b1;
        end
        return s;
    endfunction

    // the whole back pipeline moves together; it halts only while a result waits unread
    assign en      = !res_valid_reg || res_pop;
    assign in_take = en && in_valid;

    // centre offsets, saturation and squared offsets
    always_comb
    begin
        logic [MAG_W-1:0]        q;
        logic signed [OFF_W-1:0] off;
        logic signed [OFF_W:0]   cs;
        logic [OFF_W-CEN_W+1:0]  top;
        x1_satc_next = 1'b0;
        x1_big_next  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            q   = da_reg[MAG_W][k][MAG_W-1:0];
            off = $signed({1'b0, q});
            if (ds_reg[MAG_W].neg[k])
            begin
                off = -off;
            end
            cs  = (OFF_W+1)'(off) + (OFF_W+1)'($signed(ds_reg[MAG_W].org[k]));
            top = cs[OFF_W:CEN_W-1];
            if ((&top) || !(|top))
            begin
                x1_cen_next[k] = cs[CEN_W-1:0];
            end
            else
            begin
                x1_cen_next[k] = cs[OFF_W] ? CEN_MIN : CEN_MAX;
                x1_satc_next   = 1'b1;
            end
            if (|q[MAG_W-1:RAD_W])
            begin
                x1_big_next = 1'b1;
            end
            x1_sq_next[k] = SQ_W'(q[RAD_W-1:0]) * SQ_W'(q[RAD_W-1:0]);
        end
    end

    always_comb
    begin
        r2 = (SQ_W+2)'(x1_sq_reg[0]) + (SQ_W+2)'(x1_sq_reg[1]) + (SQ_W+2)'(x1_sq_reg[2]);
        info0.cen[0] = x1_cen_reg[0];
        info0.cen[1] = x1_cen_reg[1];
        info0.cen[2] = x1_cen_reg[2];
        info0.satc   = x1_satc_reg;
        info0.rsat   = x1_big_reg || (r2[SQ_W+1:SQ_W] != '0) || (r2[SQ_W-1:0] > RAD_LIMIT);
        info0.cop    = x1_cop_reg;
    end

    // digit-by-digit square root, keeping the remainder for rounding
    always_comb
    begin
        logic [SREM_W-1:0] rem2, trial;
        for (int s = 1; s <= SQRT_STEPS; s++)
        begin
            rem2  = {sr_rem_reg[s-1][SREM_W-3:0], sr_v_reg[s-1][SQ_W-1:SQ_W-2]};
            trial = SREM_W'({sr_root_reg[s-1], 2'b01});
            if (rem2 >= trial)
            begin
                sr_rem_next[s]  = rem2 - trial;
                sr_root_next[s] = {sr_root_reg[s-1][RAD_W-2:0], 1'b1};
            end
            else
            begin
                sr_rem_next[s]  = rem2;
                sr_root_next[s] = {sr_root_reg[s-1][RAD_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        info_t            fi;
        logic [RAD_W-1:0] root;
        logic             rnd;
        fi   = sr_info_reg[SQRT_STEPS];
        root = sr_root_reg[SQRT_STEPS];
        rnd  = sr_rem_reg[SQRT_STEPS] > SREM_W'(root);
        if (fi.cop)
        begin
            res_next.centre_x      = '0;
            res_next.centre_y      = '0;
            res_next.centre_z      = '0;
            res_next.sphere_radius = '0;
            res_next.fit_status    = ST_COPLANAR;
        end
        else
        begin
            res_next.centre_x      = fi.cen[0];
            res_next.centre_y      = fi.cen[1];
            res_next.centre_z      = fi.cen[2];
            res_next.sphere_radius = fi.rsat ? '1 : root + RAD_W'(rnd);
            res_next.fit_status    = (fi.satc || fi.rsat) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                da_reg[0][k] <= {{REM_W{1'b0}}, in_item.mag[k]};
            end
            dd_reg[0] <= in_item.dvs;
            ds_reg[0] <= in_item.side;
            for (int s = 1; s <= MAG_W; s++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    da_reg[s][k] <= div_step(da_reg[s-1][k], dd_reg[s-1]);
                end
                ds_reg[s] <= ds_reg[s-1];
            end
            for (int s = 1; s < MAG_W; s++)
            begin
                dd_reg[s] <= dd_reg[s-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                x1_cen_reg[k] <= x1_cen_next[k];
                x1_sq_reg[k]  <= x1_sq_next[k];
            end
            x1_satc_reg <= x1_satc_next;
            x1_big_reg  <= x1_big_next;
            x1_cop_reg  <= ds_reg[MAG_W].coplanar;
            sr_rem_reg[0]  <= '0;
            sr_root_reg[0] <= '0;
            sr_v_reg[0]    <= r2[SQ_W-1:0];
            sr_info_reg[0] <= info0;
            for (int s = 1; s <= SQRT_STEPS; s++)
            begin
                sr_rem_reg[s]  <= sr_rem_next[s];
                sr_root_reg[s] <= sr_root_next[s];
                sr_info_reg[s] <= sr_info_reg[s-1];
            end
            for (int s = 1; s < SQRT_STEPS; s++)
            begin
                sr_v_reg[s] <= sr_v_reg[s-1] << 2;
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg        <= '0;
            x1_v_reg      <= 1'b0;
            sv_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg        <= {dv_reg[MAG_W-1:0], in_valid};
            x1_v_reg      <= dv_reg[MAG_W];
            sv_reg        <= {sv_reg[SQRT_STEPS-1:0], x1_v_reg};
            res_valid_reg <= sv_reg[SQRT_STEPS];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> design/sphere_from_four_points.sv
// sphere_from_four_points: top level of the four-point sphere fit
// depends on sff_pkg, sff_front, sff_queue, sff_back
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+----------------------------
//  points    | in        | push / full       | point_set (sff_in_t)
//  sphere    | out       | pop / empty       | sphere (sff_out_t)
//
// one request per cycle sustained while no result waits unread; an accepted request
// passes 5 front stages, the queue (memory and head register), 74 division
// stages (operand load plus 73 quotient bits), 2 for the centre and squared
// radius, 32 square root stages and the result register.
// reset clears all valid and pointer state; no clearing pass is needed.
// a result left unread halts the back pipeline; the front keeps taking points
// until the queue credits (16) are used up, then full rises.
module sphere_from_four_points import sff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  sff_in_t  point_set,
    output logic     empty,
    input  logic     pop,
    output sff_out_t sphere
);

    logic     take;
    logic     mid_wr;
    sff_mid_t mid_item;
    logic     head_valid;
    sff_mid_t head;
    logic     head_take;
    logic     res_valid;

    assign take = push && !full;

    sff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .pts       (point_set),
        .out_valid (mid_wr),
        .item      (mid_item)
    );

    sff_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .reserve    (take),
        .full       (full),
        .wr         (mid_wr),
        .wdata      (mid_item),
        .head_valid (head_valid),
        .head       (head),
        .rd         (head_take)
    );

    sff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (head_valid),
        .in_item   (head),
        .in_take   (head_take),
        .res_valid (res_valid),
        .res       (sphere),
        .res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule
